// ----- sv/psht_pkg.sv -----
// Shared constants for the polyline surface hit test block.
`default_nettype none

package psht_pkg;

    localparam int MAX_POINTS = 32;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int COORD_W    = 16;
    localparam int PIU_W      = 6;
    localparam logic [PIU_W-1:0] PIU_RESET = 6'd20;

    // Multiplier: 19-bit signed by 17-bit signed operand.
    localparam int MUL_A_W = COORD_W + 3;
    localparam int MUL_B_W = COORD_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // The quotient magnitude never exceeds the y span of a segment.
    localparam int DIV_STEPS = COORD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

endpackage

`default_nettype wire

// ----- sv/psht_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module psht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- sv/polyline_surface_hit_test_core.sv -----
// Polyline surface hit test: point table, segment scan and contact interpolation.
// A load item is written to the point table and gives no result; loads may come back to back.
// A query walks the segments through one RAM read port and one shared multiplier:
// it reads the first point, then for each segment scanned reads the next point,
// checks the span and compares products, and on a hit runs the iterative floor division.
// Reset (rst_n low, asynchronous) empties the output register and loads points_in_use = 20.
`default_nettype none

module polyline_surface_hit_test_core
    import psht_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // Input items.
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // point_index[4:0], point_x[20:5], point_y[36:21], box_left[52:37],
    // box_top[68:53], box_width[83:69], box_height[98:84], zero[103:99]
    input  wire logic [103:0]      s_axis_tdata,
    // command[0]
    input  wire logic              s_axis_tuser,
    // Result items.
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // contact_x[16:0], contact_y[32:17], zero[39:33]
    output logic [39:0]            m_axis_tdata,
    // hit[0]
    output logic                   m_axis_tuser,
    // points_in_use register.
    input  wire logic              cfg_we,
    input  wire logic [PIU_W-1:0]  cfg_wdata
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_GRAB,
        ST_SPAN,
        ST_MUL2,
        ST_CMP,
        ST_NEXT,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } state_t;

    state_t                      state_reg;
    logic [ADDR_W-1:0]           idx_reg;
    logic [PIU_W-1:0]            piu_reg;
    logic signed [COORD_W:0]     centre_reg;
    logic signed [COORD_W:0]     bottom_reg;
    logic signed [COORD_W-1:0]   x0_reg;
    logic signed [COORD_W-1:0]   y0_reg;
    logic signed [COORD_W-1:0]   x1_reg;
    logic signed [COORD_W-1:0]   y1_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [PROD_W-1:0]    num_reg;
    logic [COORD_W-1:0]          den_reg;
    logic [COORD_W-1:0]          rem_reg;
    logic [COORD_W-1:0]          dq_reg;
    logic                        neg_reg;
    logic [DIV_CNT_W-1:0]        div_cnt_reg;
    logic                        res_hit_reg;
    logic signed [COORD_W-1:0]   res_y_reg;
    logic                        m_valid_reg;
    logic                        m_hit_reg;
    logic signed [COORD_W:0]     m_x_reg;
    logic signed [COORD_W-1:0]   m_y_reg;

    // Input fields.
    logic [ADDR_W-1:0]           in_index;
    logic [COORD_W-1:0]          in_px;
    logic [COORD_W-1:0]          in_py;
    logic signed [COORD_W-1:0]   in_left;
    logic signed [COORD_W-1:0]   in_top;
    logic [COORD_W-2:0]          in_width;
    logic [COORD_W-2:0]          in_height;

    logic [PIU_W-1:0]            n_eff;
    logic                        ram_we;
    logic [2*COORD_W-1:0]        ram_rdata;

    logic signed [COORD_W:0]     x0_ext;
    logic signed [COORD_W:0]     x1_ext;
    logic signed [COORD_W:0]     y0_ext;
    logic                        in_span;
    logic signed [COORD_W+1:0]   cx_off;
    logic signed [COORD_W:0]     dx;
    logic signed [COORD_W:0]     dy;
    logic signed [MUL_A_W-1:0]   kp1;
    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]    prod;
    logic signed [PROD_W-1:0]    num_mag;
    logic [COORD_W:0]            div_t;
    logic                        div_ge;
    logic signed [COORD_W+1:0]   quot;
    logic signed [COORD_W+1:0]   height_full;

    assign in_index  = s_axis_tdata[4:0];
    assign in_px     = s_axis_tdata[20:5];
    assign in_py     = s_axis_tdata[36:21];
    assign in_left   = s_axis_tdata[52:37];
    assign in_top    = s_axis_tdata[68:53];
    assign in_width  = s_axis_tdata[83:69];
    assign in_height = s_axis_tdata[98:84];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_hit_reg;
    assign m_axis_tdata  = {7'd0, m_y_reg, m_x_reg};

    assign n_eff = (piu_reg > PIU_W'(MAX_POINTS)) ? PIU_W'(MAX_POINTS) : piu_reg;

    // Every slot of the point table is addressable, so all loads are written.
    assign ram_we = s_axis_tready && s_axis_tvalid && (s_axis_tuser == CMD_LOAD);

    psht_ram #(
        .WIDTH (2 * COORD_W),
        .DEPTH (MAX_POINTS)
    ) u_point_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_index),
        .wdata ({in_py, in_px}),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // Segment arithmetic shared by the scan steps.
    always_comb
    begin
        x0_ext  = {x0_reg[COORD_W-1], x0_reg};
        x1_ext  = {x1_reg[COORD_W-1], x1_reg};
        y0_ext  = {y0_reg[COORD_W-1], y0_reg};
        in_span = (centre_reg >= x0_ext) && (centre_reg <= x1_ext);
        cx_off  = {centre_reg[COORD_W], centre_reg} - {x0_ext[COORD_W], x0_ext};
        dx      = x1_ext - x0_ext;
        dy      = {y1_reg[COORD_W-1], y1_reg} - y0_ext;
        // One more than the allowed drop below y0: floor(N/D) <= k exactly when N < (k+1)*D.
        kp1     = MUL_A_W'(bottom_reg) - MUL_A_W'(y0_ext) + MUL_A_W'(1);
        if (state_reg == ST_SPAN)
        begin
            mul_a = MUL_A_W'(dy);
            mul_b = {1'b0, cx_off[COORD_W-1:0]};
        end
        else
        begin
            mul_a = kp1;
            mul_b = {1'b0, den_reg};
        end
        prod    = mul_a * mul_b;
        num_mag = num_reg[PROD_W-1] ? -num_reg : num_reg;

        div_t   = {rem_reg, dq_reg[COORD_W-1]};
        div_ge  = (div_t >= {1'b0, den_reg});

        if (neg_reg)
        begin
            quot = -$signed({2'b00, dq_reg}) - $signed({{(COORD_W+1){1'b0}}, (rem_reg != '0)});
        end
        else
        begin
            quot = $signed({2'b00, dq_reg});
        end
        height_full = {y0_ext[COORD_W], y0_ext} + quot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            piu_reg     <= PIU_RESET;
            centre_reg  <= '0;
            bottom_reg  <= '0;
            x0_reg      <= '0;
            y0_reg      <= '0;
            x1_reg      <= '0;
            y1_reg      <= '0;
            prod_reg    <= '0;
            num_reg     <= '0;
            den_reg     <= '0;
            rem_reg     <= '0;
            dq_reg      <= '0;
            neg_reg     <= 1'b0;
            div_cnt_reg <= '0;
            res_hit_reg <= 1'b0;
            res_y_reg   <= '0;
            m_valid_reg <= 1'b0;
            m_hit_reg   <= 1'b0;
            m_x_reg     <= '0;
            m_y_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                piu_reg <= cfg_wdata;
            end
            // In ST_OUT the output register is refilled below instead.
            if (m_valid_reg && m_axis_tready && (state_reg != ST_OUT))
            begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid && (s_axis_tuser == CMD_QUERY))
                    begin
                        centre_reg <= {in_left[COORD_W-1], in_left}
                                      + {3'b000, in_width[COORD_W-2:1]};
                        bottom_reg <= {in_top[COORD_W-1], in_top} + {2'b00, in_height};
                        idx_reg    <= '0;
                        if (n_eff < PIU_W'(2))
                        begin
                            res_hit_reg <= 1'b0;
                            state_reg   <= ST_OUT;
                        end
                        else
                        begin
                            state_reg <= ST_FETCH;
                        end
                    end
                end

                ST_FETCH:
                begin
                    state_reg <= ST_GRAB;
                end

                ST_GRAB:
                begin
                    if (idx_reg == '0)
                    begin
                        x0_reg    <= ram_rdata[COORD_W-1:0];
                        y0_reg    <= ram_rdata[2*COORD_W-1:COORD_W];
                        idx_reg   <= ADDR_W'(1);
                        state_reg <= ST_FETCH;
                    end
                    else
                    begin
                        x1_reg    <= ram_rdata[COORD_W-1:0];
                        y1_reg    <= ram_rdata[2*COORD_W-1:COORD_W];
                        state_reg <= ST_SPAN;
                    end
                end

                ST_SPAN:
                begin
                    if (!in_span)
                    begin
                        state_reg <= ST_NEXT;
                    end
                    else if (dx == '0)
                    begin
                        // A zero-width segment takes the height of its first point.
                        if (bottom_reg >= y0_ext)
                        begin
                            res_hit_reg <= 1'b1;
                            res_y_reg   <= y0_reg;
                            state_reg   <= ST_OUT;
                        end
                        else
                        begin
                            state_reg <= ST_NEXT;
                        end
                    end
                    else
                    begin
                        prod_reg  <= prod;
                        den_reg   <= dx[COORD_W-1:0];
                        state_reg <= ST_MUL2;
                    end
                end

                ST_MUL2:
                begin
                    num_reg   <= prod_reg;
                    prod_reg  <= prod;
                    state_reg <= ST_CMP;
                end

                ST_CMP:
                begin
                    if (num_reg < prod_reg)
                    begin
                        neg_reg     <= num_reg[PROD_W-1];
                        rem_reg     <= num_mag[2*COORD_W-1:COORD_W];
                        dq_reg      <= num_mag[COORD_W-1:0];
                        div_cnt_reg <= '0;
                        state_reg   <= ST_DIV;
                    end
                    else
                    begin
                        state_reg <= ST_NEXT;
                    end
                end

                ST_NEXT:
                begin
                    x0_reg <= x1_reg;
                    y0_reg <= y1_reg;
                    if ((PIU_W'(idx_reg) + PIU_W'(1)) >= n_eff)
                    begin
                        res_hit_reg <= 1'b0;
                        state_reg   <= ST_OUT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + ADDR_W'(1);
                        state_reg <= ST_FETCH;
                    end
                end

                ST_DIV:
                begin
                    // Restoring division, one quotient bit per cycle.
                    rem_reg     <= div_ge ? COORD_W'(div_t - {1'b0, den_reg})
                                          : div_t[COORD_W-1:0];
                    dq_reg      <= {dq_reg[COORD_W-2:0], div_ge};
                    div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                    if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                    begin
                        state_reg <= ST_FIN;
                    end
                end

                ST_FIN:
                begin
                    res_hit_reg <= 1'b1;
                    res_y_reg   <= height_full[COORD_W-1:0];
                    state_reg   <= ST_OUT;
                end

                ST_OUT:
                begin
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_hit_reg   <= res_hit_reg;
                        m_x_reg     <= res_hit_reg ? centre_reg : '0;
                        m_y_reg     <= res_hit_reg ? res_y_reg : '0;
                        state_reg   <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // A miss carries zero contact coordinates.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("miss result with nonzero contact");

    // A query holds off further input for at least the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_QUERY)) |=> !s_axis_tready)
        else $error("input taken while a query is in progress");

    // The divider only runs on a segment of nonzero width.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (den_reg != '0))
        else $error("division by a zero-width segment");

    // The scan never reads past the last point in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SPAN) |-> (PIU_W'(idx_reg) < n_eff))
        else $error("segment index beyond points in use");

    // The final step of an interpolated hit is only ever entered from the divider.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FIN) && !$past(state_reg == ST_DIV)) |-> 1'b0)
        else $error("division finished without running");

endmodule

`default_nettype wire
